@@ rtl/core/aids_pkg.sv @@
package aids_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_WORD_WIDTH = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int FOUND_W  = 4;
  localparam int MASK_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 3'd0,
    OP_INSERT     = 3'd1,
    OP_DEL_POS    = 3'd2,
    OP_DEL_VAL    = 3'd3,
    OP_FIND_FIRST = 3'd4,
    OP_FIND_ALL   = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Per-cell steering for one cycle; at most one bit is set.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_cmd_t;

endpackage

@@ rtl/core/aids_cmd_if.sv @@
interface aids_cmd_if;
  import aids_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

@@ rtl/core/aids_rsp_if.sv @@
interface aids_rsp_if;
  import aids_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      count;
  logic [FOUND_W-1:0]      found_index;
  logic [MASK_W-1:0]       match_mask;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output status, output count, output found_index,
                  output match_mask, output read_value, input ready);
  modport sink (input valid, input status, input count, input found_index,
                input match_mask, input read_value, output ready);
endinterface

@@ rtl/core/aids_cell.sv @@
module aids_cell #(
  parameter int WORD_WIDTH = aids_pkg::DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  aids_pkg::cell_cmd_t   cmd,
  input  logic [WORD_WIDTH-1:0] word,
  input  logic [WORD_WIDTH-1:0] left,
  input  logic [WORD_WIDTH-1:0] right,
  output logic [WORD_WIDTH-1:0] data,
  output logic                  eq
);
  import aids_pkg::*;

  logic [WORD_WIDTH-1:0] data_next;

  always_comb begin
    if (cmd.load) begin
      data_next = word;
    end else if (cmd.take_left) begin
      data_next = left;
    end else if (cmd.take_right) begin
      data_next = right;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign eq = (data == word);

endmodule

@@ rtl/core/aids_ctrl.sv @@
module aids_ctrl #(
  parameter int CAPACITY   = aids_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = aids_pkg::DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  aids_cmd_if.sink              cmd,
  aids_rsp_if.source            rsp,
  input  logic [WORD_WIDTH-1:0] cell_data [CAPACITY],
  input  logic [CAPACITY-1:0]   eq,
  output logic [WORD_WIDTH-1:0] word,
  output aids_pkg::cell_cmd_t   cell_cmd [CAPACITY]
);
  import aids_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int CPW = (CW > POS_W) ? CW : POS_W;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         k, k_next;
  logic                  removed, removed_next;
  logic                  scan_del;
  logic [WORD_WIDTH-1:0] val_reg;

  logic                  accept;
  op_t                   op;
  logic [WORD_WIDTH-1:0] in_word;
  logic [CPW-1:0]        pos_c;
  logic [CPW-1:0]        cnt_c;
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   all_hits;
  logic                  scan_end;
  logic                  scan_hit;
  logic                  ins_ok;

  logic                  res_load;
  stat_t                 res_status;
  logic [FOUND_W-1:0]    res_found;
  logic [MASK_W-1:0]     res_mask;
  logic [VAL_W-1:0]      res_read;

  assign cmd.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign op        = op_t'(cmd.operation);
  assign in_word   = WORD_WIDTH'($signed(cmd.value));
  assign word      = (state == ST_IDLE) ? in_word : val_reg;
  assign pos_c     = CPW'(cmd.position);
  assign cnt_c     = CPW'(count);
  assign ins_ok    = (pos_c <= cnt_c) && (count < CW'(CAPACITY));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = (CW'(i) < count);
    end
  end

  assign all_hits = eq & valid_vec;
  assign scan_end = (k >= count);
  assign scan_hit = !scan_end && eq[k[IW-1:0]];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_DEL_VAL || op == OP_FIND_FIRST)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end || (scan_hit && !scan_del)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next   = count;
    k_next       = k;
    removed_next = removed;
    res_load     = 1'b0;
    res_status   = STAT_OK;
    res_found    = '0;
    res_mask     = '0;
    res_read     = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_cmd[i] = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_INSERT: begin
              if (pos_c > cnt_c) begin
                res_status = STAT_BAD_POS;
              end else if (!ins_ok) begin
                res_status = STAT_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_cmd[i].load      = (CPW'(i) == pos_c);
                  cell_cmd[i].take_left = (CPW'(i) > pos_c);
                end
                count_next = CW'(count + CW'(1));
              end
            end
            OP_DEL_POS: begin
              if (pos_c >= cnt_c) begin
                res_status = STAT_BAD_POS;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  cell_cmd[i].take_right = (CPW'(i) >= pos_c);
                end
                count_next = CW'(count - CW'(1));
              end
            end
            OP_DEL_VAL, OP_FIND_FIRST: begin
              res_load     = 1'b0;
              k_next       = '0;
              removed_next = 1'b0;
            end
            OP_FIND_ALL: begin
              res_mask   = MASK_W'(all_hits);
              res_status = (|all_hits) ? STAT_OK : STAT_NOT_FOUND;
            end
            OP_READ: begin
              if (pos_c >= cnt_c) begin
                res_status = STAT_BAD_POS;
              end else begin
                res_read = VAL_W'($signed(cell_data[pos_c[IW-1:0]]));
              end
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          res_load   = 1'b1;
          res_status = (scan_del && removed) ? STAT_OK : STAT_NOT_FOUND;
        end else if (scan_hit) begin
          if (scan_del) begin
            // Close the gap at the pointer and test the same slot again.
            for (int i = 0; i < CAPACITY; i++) begin
              cell_cmd[i].take_right = (CW'(i) >= k);
            end
            count_next   = CW'(count - CW'(1));
            removed_next = 1'b1;
          end else begin
            res_load  = 1'b1;
            res_found = FOUND_W'(k);
          end
        end else begin
          k_next = CW'(k + CW'(1));
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      k         <= '0;
      removed   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      k       <= k_next;
      removed <= removed_next;
      if (res_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_reg  <= in_word;
      scan_del <= (op == OP_DEL_VAL);
    end
    if (res_load) begin
      rsp.status      <= res_status;
      rsp.count       <= COUNT_W'(count_next);
      rsp.found_index <= res_found;
      rsp.match_mask  <= res_mask;
      rsp.read_value  <= res_read;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> k <= count)
    else $error("scan pointer beyond entry count");

  a_scan_shrink: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |=> count <= $past(count))
    else $error("entry count grew during a scan");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_INSERT && ins_ok) |=> count == $past(count) + 1)
    else $error("accepted insert did not add an entry");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!rsp.valid || rsp.ready))
    else $error("item accepted while a result was blocked");
`endif

endmodule

@@ rtl/core/array_insert_delete_search.sv @@
// Latency: clear, insert, delete at position, search all and read return their
// result one cycle after the item is accepted. Search first and delete by value
// take up to count+1 cycles: a pointer visits one entry a cycle, and a matching
// entry under delete by value is shifted out in that cycle instead of stepped past.
// Throughput: one item per cycle for the single-cycle commands when results are taken.
// Reset (synchronous, active high) empties the list; stored words keep old contents.
module array_insert_delete_search #(
  parameter int CAPACITY   = aids_pkg::DEF_CAPACITY,
  parameter int WORD_WIDTH = aids_pkg::DEF_WORD_WIDTH
) (
  input logic        clk,
  input logic        rst,
  aids_cmd_if.sink   cmd,
  aids_rsp_if.source rsp
);
  import aids_pkg::*;

  logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   eq;
  logic [WORD_WIDTH-1:0] word;
  cell_cmd_t             cell_cmd [CAPACITY];

  aids_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .cell_data(cell_data),
    .eq       (eq),
    .word     (word),
    .cell_cmd (cell_cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left;
    logic [WORD_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    aids_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk  (clk),
      .cmd  (cell_cmd[i]),
      .word (word),
      .left (left),
      .right(right),
      .data (cell_data[i]),
      .eq   (eq[i])
    );
  end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import aids_pkg::*;

  localparam int                DEPTH      = DEF_CAPACITY;
  localparam int                IDLE_LIMIT = 4000;
  localparam int                LONG_HOLD  = 300;
  localparam int                RANDOM_CMDS = 500;
  localparam logic [OP_W-1:0]   OP_UNUSED  = 3'd7;

  typedef struct {
    stat_t                   status;
    logic [COUNT_W-1:0]      count;
    logic [FOUND_W-1:0]      found_index;
    logic [MASK_W-1:0]       match_mask;
    logic signed [VAL_W-1:0] read_value;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] words[DEPTH];
    int unsigned             fill;
    list_result_t            pending_q[$];
    int                      errors;
    int                      results_seen;
    int                      cmds_seen;
    int                      full_refusals;
    int                      op_hits[8];

    function new();
      fill = 0;
      errors = 0;
      results_seen = 0;
      cmds_seen = 0;
      full_refusals = 0;
      foreach (op_hits[i]) op_hits[i] = 0;
    endfunction

    // Apply one accepted command to the shadow list and queue its result.
    function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val);
      list_result_t res;
      int unsigned  keep;
      res.status      = STAT_OK;
      res.found_index = '0;
      res.match_mask  = '0;
      res.read_value  = '0;
      cmds_seen++;
      op_hits[op]++;
      case (op)
        OP_CLEAR: begin
          fill = 0;
        end
        OP_INSERT: begin
          if (pos > fill) begin
            res.status = STAT_BAD_POS;
          end else if (fill >= DEPTH) begin
            res.status = STAT_FULL;
            full_refusals++;
          end else begin
            for (int i = fill; i > pos; i--) words[i] = words[i-1];
            words[pos] = val;
            fill++;
          end
        end
        OP_DEL_POS: begin
          if (pos >= fill) begin
            res.status = STAT_BAD_POS;
          end else begin
            for (int i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        OP_DEL_VAL: begin
          keep = 0;
          for (int i = 0; i < fill; i++) begin
            if (words[i] != val) begin
              words[keep] = words[i];
              keep++;
            end
          end
          if (keep == fill) res.status = STAT_NOT_FOUND;
          fill = keep;
        end
        OP_FIND_FIRST: begin
          res.status = STAT_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (words[i] == val && res.status == STAT_NOT_FOUND) begin
              res.found_index = i[FOUND_W-1:0];
              res.status = STAT_OK;
            end
          end
        end
        OP_FIND_ALL: begin
          res.status = STAT_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (words[i] == val) begin
              res.status = STAT_OK;
              if (i < MASK_W) res.match_mask[i] = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (pos >= fill) res.status = STAT_BAD_POS;
          else res.read_value = words[pos];
        end
        default: begin
        end
      endcase
      res.count = fill[COUNT_W-1:0];
      pending_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic [FOUND_W-1:0] found_index,
                               logic [MASK_W-1:0] match_mask,
                               logic signed [VAL_W-1:0] read_value);
      list_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, status, count);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("status", want.status, status);
      compare_field("count", want.count, count);
      compare_field("found_index", want.found_index, found_index);
      compare_field("match_mask", want.match_mask, match_mask);
      compare_field("read_value", want.read_value, read_value);
    endfunction
  endclass

  logic clk;
  logic rst;

  aids_cmd_if cmd_bus ();
  aids_rsp_if rsp_bus ();

  array_insert_delete_search DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  list_scoreboard sb = new();

  int cmd_left;
  bit cmd_quiet;
  int rsp_left;
  bit rsp_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles come in stretches: some stretches have no gaps at all.
  function automatic int draw_gap(ref int left, ref bit quiet);
    if (left == 0) begin
      left  = $urandom_range(10, 40);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                          logic signed [VAL_W-1:0] val);
    int gap;
    gap = draw_gap(cmd_left, cmd_quiet);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= op;
    cmd_bus.position  <= pos;
    cmd_bus.value     <= val;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    sb.note_command(op, pos, val);
  endtask

  task automatic run_directed();
    send_cmd(OP_CLEAR, 0, 0);
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_DEL_POS, 0, 0);
    send_cmd(OP_DEL_VAL, 0, 5);
    send_cmd(OP_FIND_FIRST, 0, 5);
    send_cmd(OP_FIND_ALL, 0, 5);
    send_cmd(OP_INSERT, 1, 9);
    send_cmd(OP_INSERT, 0, 32'sh7fffffff);
    send_cmd(OP_INSERT, 0, 32'sh80000000);
    send_cmd(OP_INSERT, 2, -1);
    // Fill to capacity with a repeated word spread out to the last slot.
    for (int k = 3; k < DEPTH; k++)
      send_cmd(OP_INSERT, k[POS_W-1:0], (k % 4 == 0 || k == DEPTH - 1) ? 5 : k);
    send_cmd(OP_INSERT, 16, 1);
    send_cmd(OP_READ, 16, 0);
    send_cmd(OP_READ, 1, 0);
    send_cmd(OP_READ, 0, 0);
    send_cmd(OP_FIND_FIRST, 0, 5);
    send_cmd(OP_FIND_ALL, 0, 5);
    send_cmd(OP_UNUSED, 31, -1);
    send_cmd(OP_DEL_POS, 15, 0);
    send_cmd(OP_DEL_POS, 0, 0);
    send_cmd(OP_DEL_VAL, 0, 5);
    send_cmd(OP_DEL_VAL, 0, 5);
  endtask

  task automatic run_random(int n);
    logic signed [VAL_W-1:0] word_pool[6];
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      r;
    bit                      grow;
    word_pool = '{0, -1, 7, 42, 32'sh7fffffff, 32'sh80000000};
    for (int i = 0; i < n; i++) begin
      // Alternate between phases that fill the list and phases that drain it.
      grow = ((i / 60) % 2 == 0);
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_CLEAR;
      else if (r < 3) op = OP_UNUSED;
      else if (r < (grow ? 55 : 28)) op = OP_INSERT;
      else if (r < (grow ? 63 : 50)) op = OP_DEL_POS;
      else if (r < (grow ? 71 : 64)) op = OP_DEL_VAL;
      else if (r < (grow ? 80 : 76)) op = OP_FIND_FIRST;
      else if (r < (grow ? 90 : 88)) op = OP_FIND_ALL;
      else op = OP_READ;
      if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, sb.fill));
      else pos = POS_W'($urandom_range(0, 16));
      if ($urandom_range(0, 9) < 7) val = word_pool[$urandom_range(0, 5)];
      else val = $urandom;
      send_cmd(op, pos, val);
    end
  endtask

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold that backs up the block.
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    rsp_left = 0;
    @(negedge rst);
    forever begin
      if (sb.results_seen == 200) stall = LONG_HOLD;
      else stall = draw_gap(rsp_left, rsp_quiet);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
      sb.check_result(rsp_bus.status, rsp_bus.count, rsp_bus.found_index,
                      rsp_bus.match_mask, rsp_bus.read_value);
    end
  end

  initial begin
    rst               = 1'b1;
    cmd_bus.valid     = 1'b0;
    cmd_bus.operation = OP_CLEAR;
    cmd_bus.position  = '0;
    cmd_bus.value     = '0;
    cmd_left          = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_CMDS);
    cmd_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    // Longest command is delete by value on a full list.
    repeat (2 * DEPTH + 20) @(posedge clk);
    $display("Ran %0d commands and checked %0d results; %0d inserts hit a full list.",
             sb.cmds_seen, sb.results_seen, sb.full_refusals);
    $display("Commands by kind: clear %0d, insert %0d, delete at position %0d, %s %0d,",
             sb.op_hits[OP_CLEAR], sb.op_hits[OP_INSERT], sb.op_hits[OP_DEL_POS],
             "delete by value", sb.op_hits[OP_DEL_VAL]);
    $display("  search first %0d, search all %0d, read %0d, unused code %0d.",
             sb.op_hits[OP_FIND_FIRST], sb.op_hits[OP_FIND_ALL], sb.op_hits[OP_READ],
             sb.op_hits[OP_UNUSED]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
